@@ sv/lpg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Line pixel generator package
// Shared item types, widths and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package lpg_pkg;

	localparam int COORD_W          = 6;
	localparam int COORD_BITS_DEF   = 6;

	typedef struct packed {
		logic [COORD_W-1:0] x_start;
		logic [COORD_W-1:0] y_start;
		logic [COORD_W-1:0] x_end;
		logic [COORD_W-1:0] y_end;
	} seg_item_t;

	typedef struct packed {
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
		logic               last_pixel;
	} pix_item_t;

	typedef struct packed {
		logic load;
		logic step;
	} lpg_cmd_t;

	typedef struct packed {
		logic zero_len;
		logic last;
	} lpg_sts_t;

endpackage

`default_nettype wire

@@ sv/line_pixel_generator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Line pixel generator
// Walks a segment with integer Bresenham stepping, one pixel per cycle while
// the output is not stalled. The segment loads into the walk registers, the
// controller enters its run state, and each step registers one pixel; the
// input stalls until the walk ends, and a zero-length segment emits no pixel.
// Reset clears the controller state and the output valid flag.
// ----------------------------------------------------------------------------
module line_pixel_generator
	import lpg_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      seg_valid,
	output logic           seg_stall,
	input  wire seg_item_t seg,
	output logic           pix_valid,
	input  wire logic      pix_stall,
	output pix_item_t      pix
);

	lpg_cmd_t cmd;
	lpg_sts_t sts;

	lpg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_valid (seg_valid),
		.seg_stall (seg_stall),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	lpg_dp #(
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk (clk),
		.seg (seg),
		.pix (pix),
		.cmd (cmd),
		.sts (sts)
	);

endmodule

`default_nettype wire

@@ sv/lpg_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Line pixel generator controller
// Sequences segment load and pixel stepping, owns the output valid flag.
// ----------------------------------------------------------------------------
module lpg_ctrl
	import lpg_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     seg_valid,
	output logic          seg_stall,
	output logic          pix_valid,
	input  wire logic     pix_stall,
	output lpg_cmd_t      cmd,
	input  wire lpg_sts_t sts
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic state_q;
	logic state_d;
	logic pix_valid_q;

	always_comb begin
		cmd.load = (state_q == ST_IDLE) && seg_valid;
		cmd.step = (state_q == ST_RUN) && (!pix_valid_q || !pix_stall);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.load && !sts.zero_len) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (cmd.step && sts.last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pix_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.step) begin
				pix_valid_q <= 1'b1;
			end else if (!pix_stall) begin
				pix_valid_q <= 1'b0;
			end
		end
	end

	assign seg_stall = (state_q != ST_IDLE);
	assign pix_valid = pix_valid_q;

endmodule

`default_nettype wire

@@ sv/lpg_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Line pixel generator datapath
// Holds the Bresenham walk state and the output pixel register.
// ----------------------------------------------------------------------------
module lpg_dp
	import lpg_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic      clk,
	input  wire seg_item_t seg,
	output pix_item_t      pix,
	input  wire lpg_cmd_t  cmd,
	output lpg_sts_t       sts
);

	localparam int CB = COORD_BITS;
	localparam int EW = COORD_BITS + 3;

	logic [CB-1:0]        x0, y0, x1, y1;
	logic signed [CB:0]   dx, dy;
	logic [CB-1:0]        adx, ady;
	logic                 x_major;
	logic [CB-1:0]        dmaj, dmin;

	logic [CB-1:0]        x_q, y_q, cnt_q, dmaj_q, dmin_q;
	logic                 sx_neg_q, sy_neg_q, x_major_q;
	logic signed [EW-1:0] err_q;
	logic signed [EW-1:0] err_sum, dmin2, dmaj_e, dmaj2;
	logic                 minor_move;
	logic [CB-1:0]        x_inc, y_inc;
	pix_item_t            pix_q;

	always_comb begin
		x0 = seg.x_start[CB-1:0];
		y0 = seg.y_start[CB-1:0];
		x1 = seg.x_end[CB-1:0];
		y1 = seg.y_end[CB-1:0];
		dx = signed'({1'b0, x1}) - signed'({1'b0, x0});
		dy = signed'({1'b0, y1}) - signed'({1'b0, y0});
		adx = dx[CB] ? CB'(-dx) : dx[CB-1:0];
		ady = dy[CB] ? CB'(-dy) : dy[CB-1:0];
		x_major = (adx >= ady);
		dmaj = x_major ? adx : ady;
		dmin = x_major ? ady : adx;
	end

	always_comb begin
		dmin2      = signed'(EW'({dmin_q, 1'b0}));
		dmaj2      = signed'(EW'({dmaj_q, 1'b0}));
		dmaj_e     = signed'(EW'(dmaj_q));
		err_sum    = err_q + dmin2;
		minor_move = (err_sum >= dmaj_e);
		x_inc      = sx_neg_q ? (x_q - CB'(1)) : (x_q + CB'(1));
		y_inc      = sy_neg_q ? (y_q - CB'(1)) : (y_q + CB'(1));
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q       <= x0;
			y_q       <= y0;
			cnt_q     <= '0;
			err_q     <= '0;
			dmaj_q    <= dmaj;
			dmin_q    <= dmin;
			sx_neg_q  <= dx[CB];
			sy_neg_q  <= dy[CB];
			x_major_q <= x_major;
		end else if (cmd.step) begin
			pix_q.pixel_x    <= COORD_W'(x_q);
			pix_q.pixel_y    <= COORD_W'(y_q);
			pix_q.last_pixel <= (cnt_q == dmaj_q);
			cnt_q            <= cnt_q + CB'(1);
			err_q            <= minor_move ? (err_sum - dmaj2) : err_sum;
			if (x_major_q || minor_move) begin
				x_q <= x_inc;
			end
			if (!x_major_q || minor_move) begin
				y_q <= y_inc;
			end
		end
	end

	assign sts.zero_len = (dmaj == '0);
	assign sts.last     = (cnt_q == dmaj_q);
	assign pix          = pix_q;

endmodule

`default_nettype wire
